### rtl/vertex_triple_dedup_table_macros.svh
// assertion macros used by the checker file vtdt_checker.sv
// no dependencies; clk and rst_n must be visible where used
`ifndef VERTEX_TRIPLE_DEDUP_TABLE_MACROS_SVH
`define VERTEX_TRIPLE_DEDUP_TABLE_MACROS_SVH

// same-cycle implication
`define VTDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VTDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/vtdt_pkg.sv
// package for the vertex triple dedup table: payload types and constants
// no dependencies
`default_nettype none

package vtdt_pkg;

  localparam int unsigned IDX_W        = 16;
  localparam int unsigned SLOT_W       = 10;
  localparam int unsigned KEY_W        = 3 * IDX_W;
  localparam int unsigned TABLE_DEPTH  = 1024;

  typedef struct packed {
    logic             start_of_mesh;
    logic [IDX_W-1:0] pos_index;
    logic [IDX_W-1:0] tex_index;
    logic [IDX_W-1:0] normal_index;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] vertex_slot;
    logic              is_new;
    logic              table_full;
  } out_t;

  // compare result of one table entry, aligned with the ram read data
  typedef struct packed {
    logic valid;
    logic hit;
  } match_t;

endpackage

`default_nettype wire

### rtl/vtdt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module vtdt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/vtdt_cmp.sv
// shared key compare unit: tracks the index of each issued read and
// compares the returned entry against the search key; uses vtdt_pkg
`default_nettype none

module vtdt_cmp #(
  parameter int unsigned AW = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        issue,
  input  wire logic [AW-1:0]               issue_idx,
  input  wire logic [vtdt_pkg::KEY_W-1:0]  rd_data,
  input  wire logic [vtdt_pkg::KEY_W-1:0]  key,
  output vtdt_pkg::match_t                 match,
  output logic      [AW-1:0]               match_idx
);

  logic          valid_r;
  logic [AW-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= issue;
    end
    if (issue) begin
      idx_r <= issue_idx;
    end
  end

  always_comb begin
    match.valid = valid_r;
    match.hit   = valid_r && (rd_data == key);
  end

  assign match_idx = idx_r;

endmodule

`default_nettype wire

### rtl/vertex_triple_dedup_table.sv
// top level of the vertex triple dedup table: sequencer, fill count and
// output register; uses vtdt_pkg, vtdt_ram and vtdt_cmp
`default_nettype none

// Each item is one face corner {pos, tex, normal}. The block scans the filled
// entries of the table one per cycle through a single ram read port and one
// 48-bit comparator, in insertion order, and stops at the first match. On a
// miss it appends the triple at the fill count, or flags table_full when the
// table holds TABLE_DEPTH entries. start_of_mesh resets the fill count, so no
// clearing pass is needed after reset or between meshes. in_ready is high
// only between items, and the result waits in an output register while
// the next item is accepted.
module vertex_triple_dedup_table #(
  parameter int unsigned TABLE_DEPTH = vtdt_pkg::TABLE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire vtdt_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output vtdt_pkg::out_t     out_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SW = vtdt_pkg::SLOT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_OUT    = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic [vtdt_pkg::KEY_W-1:0]  key_r, key_nxt;
  vtdt_pkg::out_t              res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  vtdt_pkg::out_t              out_data_r, out_data_nxt;

  logic                        rd_en;
  logic                        wr_en;
  logic [vtdt_pkg::KEY_W-1:0]  rd_data;
  vtdt_pkg::match_t            match;
  logic [AW-1:0]               match_idx;
  logic [AW-1:0]               slot_sel;
  logic [SW+AW-1:0]            slot_wide;

  vtdt_ram #(
    .WIDTH (vtdt_pkg::KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (key_r),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  vtdt_cmp #(
    .AW (AW)
  ) u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (rd_en),
    .issue_idx (idx_r[AW-1:0]),
    .rd_data   (rd_data),
    .key       (key_r),
    .match     (match),
    .match_idx (match_idx)
  );

  // slot carries only its low bits when the table is deeper than the field
  assign slot_wide = {{SW{1'b0}}, slot_sel};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    slot_sel      = match_idx;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt   = {in_data.pos_index, in_data.tex_index, in_data.normal_index};
          count_nxt = in_data.start_of_mesh ? '0 : count_r;
          idx_nxt   = '0;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (match.hit) begin
          slot_sel            = match_idx;
          res_nxt.vertex_slot = slot_wide[SW-1:0];
          res_nxt.is_new      = 1'b0;
          res_nxt.table_full  = 1'b0;
          state_nxt           = ST_OUT;
        end else if (idx_r == count_r) begin
          // last compare has come back without a match, or the table is empty
          if (count_r < CW'(TABLE_DEPTH)) begin
            wr_en               = 1'b1;
            slot_sel            = count_r[AW-1:0];
            res_nxt.vertex_slot = slot_wide[SW-1:0];
            res_nxt.is_new      = 1'b1;
            res_nxt.table_full  = 1'b0;
            count_nxt           = count_r + CW'(1);
          end else begin
            res_nxt.vertex_slot = '0;
            res_nxt.is_new      = 1'b0;
            res_nxt.table_full  = 1'b1;
          end
          state_nxt = ST_OUT;
        end else begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    key_r      <= key_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/vtdt_checker.sv
// port-level checker for the vertex triple dedup table, bound to the top
// level; uses vtdt_pkg and vertex_triple_dedup_table_macros.svh
`default_nettype none

`include "vertex_triple_dedup_table_macros.svh"

module vtdt_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire vtdt_pkg::out_t out_data
);

  `VTDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_data), "result item changed while stalled")
  `VTDT_ASSERT_NOW(a_flags_excl, out_valid,
                   !(out_data.is_new && out_data.table_full), "is_new and table_full both set")
  `VTDT_ASSERT_NOW(a_full_slot, out_valid && out_data.table_full,
                   out_data.vertex_slot == '0, "table_full with nonzero slot")
  `VTDT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready,
                    !in_ready, "ready stayed high after an item was taken")

endmodule

bind vertex_triple_dedup_table vtdt_checker u_vtdt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

### sim/tb_vertex_triple_dedup_table.sv
// self-checking testbench for vertex_triple_dedup_table: directed corners,
// then random meshes; depends on vtdt_pkg and the rtl of vertex_triple_dedup_table
`default_nettype none

module tb_vertex_triple_dedup_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_CORNERS = 563;
  localparam int unsigned STALL_LIMIT    = 20000;
  localparam int unsigned SETTLE_CYCLES  = 1100;

  // keeps its own copy of the unique triples and predicts one slot result per item
  class corner_slot_scoreboard;
    logic [vtdt_pkg::KEY_W-1:0] triples [vtdt_pkg::TABLE_DEPTH];
    int unsigned                filled;
    vtdt_pkg::out_t             expected_slots[$];
    int unsigned                mismatches;

    function new();
      filled = 0;
      mismatches = 0;
    endfunction

    function void note_corner(vtdt_pkg::in_t c);
      logic [vtdt_pkg::KEY_W-1:0] key;
      vtdt_pkg::out_t             want;
      bit                         hit;
      key = {c.pos_index, c.tex_index, c.normal_index};
      want = '0;
      hit = 1'b0;
      if (c.start_of_mesh) filled = 0;
      // first match in insertion order wins
      for (int unsigned i = 0; i < filled && !hit; i++) begin
        if (triples[i] == key) begin
          want.vertex_slot = vtdt_pkg::SLOT_W'(i);
          hit = 1'b1;
        end
      end
      if (!hit) begin
        if (filled < vtdt_pkg::TABLE_DEPTH) begin
          triples[filled] = key;
          want.vertex_slot = vtdt_pkg::SLOT_W'(filled);
          want.is_new = 1'b1;
          filled++;
        end else begin
          want.table_full = 1'b1;
        end
      end
      expected_slots = {expected_slots, want};
    endfunction

    function int unsigned pending();
      return expected_slots.size();
    endfunction

    function void check_slot(vtdt_pkg::out_t got);
      vtdt_pkg::out_t want;
      if (expected_slots.size() == 0) begin
        $display("%0t: result with none expected, expected none, got slot %0d new %0b full %0b",
                 $time, got.vertex_slot, got.is_new, got.table_full);
        mismatches++;
        return;
      end
      want = expected_slots.pop_front();
      if (got.vertex_slot !== want.vertex_slot) begin
        $display("%0t: vertex_slot mismatch, expected %0d, got %0d",
                 $time, want.vertex_slot, got.vertex_slot);
        mismatches++;
      end
      if (got.is_new !== want.is_new) begin
        $display("%0t: is_new mismatch, expected %0b, got %0b", $time, want.is_new, got.is_new);
        mismatches++;
      end
      if (got.table_full !== want.table_full) begin
        $display("%0t: table_full mismatch, expected %0b, got %0b",
                 $time, want.table_full, got.table_full);
        mismatches++;
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  vtdt_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  vtdt_pkg::out_t out_data;

  bit steady_flow = 1'b0;
  corner_slot_scoreboard slots = new();

  vertex_triple_dedup_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic vtdt_pkg::in_t corner(logic s, logic [15:0] p, logic [15:0] t,
                                           logic [15:0] n);
    vtdt_pkg::in_t c;
    c.start_of_mesh = s;
    c.pos_index = p;
    c.tex_index = t;
    c.normal_index = n;
    return c;
  endfunction

  task automatic send_corner(input vtdt_pkg::in_t c);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    slots.note_corner(c);
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (slots.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_corner(corner(1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_corner(corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_corner(corner(1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_corner(corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // one field off from a stored triple must not match, then new triples and a repeat
    send_corner(corner(1'b0, 16'h0000, 16'h0000, 16'h0001));
    send_corner(corner(1'b0, 16'h0000, 16'h0001, 16'h0000));
    send_corner(corner(1'b0, 16'h0001, 16'h0000, 16'h0000));
    send_corner(corner(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFE));
    send_corner(corner(1'b0, 16'h8000, 16'h8000, 16'h8000));
    send_corner(corner(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_corner(corner(1'b0, 16'h0000, 16'h0000, 16'h0001));
    // new mesh: a triple seen before still lands in slot 0 as new
    send_corner(corner(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_corner(corner(1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_corner(corner(1'b1, 16'h0000, 16'h0000, 16'h0000));
    send_corner(corner(1'b1, 16'h0000, 16'h0000, 16'h0000));
    send_corner(corner(1'b0, 16'h0000, 16'h0000, 16'h0000));
    send_corner(corner(1'b0, 16'h1234, 16'hABCD, 16'h5A5A));
  endtask

  task automatic run_random_meshes();
    vtdt_pkg::in_t c;
    vtdt_pkg::in_t mesh_corners[$];
    logic          start;
    int unsigned   kind;
    for (int unsigned n = 0; n < RANDOM_CORNERS; n++) begin
      steady_flow = (n >= 200 && n < 300);
      if (n % 97 == 96) drain_results();
      start = (n == 0) || ($urandom_range(0, 29) == 0);
      if (start) mesh_corners.delete();
      kind = $urandom_range(0, 9);
      if (kind <= 5 && mesh_corners.size() > 0) begin
        c = mesh_corners[$urandom_range(0, mesh_corners.size() - 1)];
        if (kind >= 4) begin
          // near miss: one bit of one field flipped
          case ($urandom_range(0, 2))
            0: c.pos_index = c.pos_index ^ (16'h1 << $urandom_range(0, 15));
            1: c.tex_index = c.tex_index ^ (16'h1 << $urandom_range(0, 15));
            default: c.normal_index = c.normal_index ^ (16'h1 << $urandom_range(0, 15));
          endcase
        end
      end else if (kind <= 7) begin
        c = corner(1'b0, 16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)),
                   16'($urandom_range(0, 7)));
      end else begin
        c = corner(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      c.start_of_mesh = start;
      mesh_corners = {mesh_corners, c};
      send_corner(c);
    end
    steady_flow = 1'b0;
  endtask

  // result side: random back-pressure before each item, none while steady_flow is set
  initial begin
    int unsigned stall;
    wait (rst_n);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      slots.check_slot(out_data);
    end
  end

  // ends the run when no item moves on either side for too long
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    drain_results();
    run_random_meshes();
    @(negedge clk);
    in_valid <= 1'b0;
    while (slots.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (slots.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### vertex_triple_dedup_table.f
+incdir+rtl
rtl/vtdt_pkg.sv
rtl/vtdt_ram.sv
rtl/vtdt_cmp.sv
rtl/vertex_triple_dedup_table.sv
rtl/vtdt_checker.sv
sim/tb_vertex_triple_dedup_table.sv
